// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define TVAB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// check a property on every clock edge, reset included
`define TVAB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/tvab_pkg.sv =====
// Shared types and constants of the transformed-vertex bounding box block.
package tvab_pkg;

   localparam int COORD_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int COEF_BITS  = 32;

   localparam int PROD_BITS = COEF_BITS + COORD_BITS;
   localparam int SUM_BITS  = PROD_BITS + 2;

   localparam int IN_TDATA_BITS  = ((3 * COORD_BITS + 7) / 8) * 8;
   localparam int OUT_TDATA_BITS = ((6 * COORD_BITS + 7) / 8) * 8;

   localparam int CSR_COUNT     = 6;
   localparam int CSR_DATA_BITS = 2 * COEF_BITS;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_ADDR_BITS = CSR_IDX_BITS + 3;

   localparam int Q_DEPTH    = 8;
   localparam int Q_PTR_BITS = 3;
   localparam int Q_CNT_BITS = 4;

   localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   localparam logic [COEF_BITS-1:0] COEF_ONE  = COEF_BITS'(1) << FRAC_BITS;
   localparam logic [COEF_BITS-1:0] COEF_ZERO = '0;

   // row2_cols23, row2_cols01, row1_cols23, row1_cols01, row0_cols23, row0_cols01
   localparam logic [CSR_COUNT-1:0][CSR_DATA_BITS-1:0] CSR_RESET = {
      {COEF_ZERO, COEF_ONE},  {COEF_ZERO, COEF_ZERO},
      {COEF_ZERO, COEF_ZERO}, {COEF_ONE, COEF_ZERO},
      {COEF_ZERO, COEF_ZERO}, {COEF_ZERO, COEF_ONE}
   };

   // [row][column], column 3 is the translation
   typedef logic [2:0][3:0][COEF_BITS-1:0] coef_mat_type;

   typedef struct packed {
      logic                   last;
      logic [COORD_BITS-1:0]  z;
      logic [COORD_BITS-1:0]  y;
      logic [COORD_BITS-1:0]  x;
   } vtx_type;

   typedef struct packed {
      logic    valid;
      vtx_type data;
   } q_push_type;

   typedef struct packed {
      logic                  empty;
      logic [Q_CNT_BITS-1:0] count;
   } q_stat_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] max_z;
      logic [COORD_BITS-1:0] max_y;
      logic [COORD_BITS-1:0] max_x;
      logic [COORD_BITS-1:0] min_z;
      logic [COORD_BITS-1:0] min_y;
      logic [COORD_BITS-1:0] min_x;
   } box_type;

endpackage

// ===== rtl/core/tvab_csr.sv =====
// Matrix coefficient registers behind the configuration port.
module tvab_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tvab_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [tvab_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [tvab_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready,
   output tvab_pkg::coef_mat_type              coef
);
   import tvab_pkg::*;

   logic [CSR_COUNT-1:0][CSR_DATA_BITS-1:0] cfg_ff;
   logic [CSR_COUNT-1:0][CSR_DATA_BITS-1:0] cfg_in;
   logic [CSR_IDX_BITS-1:0]                 idx;
   logic                                    wr_en;

   assign csr_pready = 1'b1;
   assign idx   = csr_paddr[CSR_ADDR_BITS-1:CSR_ADDR_BITS-CSR_IDX_BITS];
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in     = cfg_ff;
      csr_prdata = '0;
      for (int i = 0; i < CSR_COUNT; i++) begin
         if (idx == CSR_IDX_BITS'(i)) begin
            csr_prdata = cfg_ff[i];
            if (wr_en) begin
               cfg_in[i] = csr_pwdata;
            end
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         coef[r][0] = cfg_ff[2*r][COEF_BITS-1:0];
         coef[r][1] = cfg_ff[2*r][CSR_DATA_BITS-1:COEF_BITS];
         coef[r][2] = cfg_ff[2*r+1][COEF_BITS-1:0];
         coef[r][3] = cfg_ff[2*r+1][CSR_DATA_BITS-1:COEF_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CSR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/tvab_queue.sv =====
// Short queue of transformed vertices between the transform pipe and the accumulator.
module tvab_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  tvab_pkg::q_push_type   push,
   input  logic                   pop,
   output tvab_pkg::vtx_type      head,
   output tvab_pkg::q_stat_type   stat
);
   import tvab_pkg::*;

   vtx_type               mem_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_BITS-1:0] count_ff, count_in;

   assign head       = mem_ff[rd_ptr_ff];
   assign stat.count = count_ff;
   assign stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + Q_PTR_BITS'(push.valid);
      rd_ptr_in = rd_ptr_ff + Q_PTR_BITS'(pop);
      count_in  = count_ff + Q_CNT_BITS'(push.valid) - Q_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.data;
      end
   end

endmodule

// ===== rtl/core/tvab_front.sv =====
// Input acceptance and pipelined affine transform with floor and saturation.
module tvab_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tvab_pkg::IN_TDATA_BITS-1:0]  req_tdata,
   input  logic                                req_tlast,
   input  tvab_pkg::coef_mat_type              coef,
   input  tvab_pkg::q_stat_type                q_stat,
   output tvab_pkg::q_push_type                push
);
   import tvab_pkg::*;

   function automatic logic [COORD_BITS-1:0] sat_floor(input logic [SUM_BITS-1:0] s);
      logic [SUM_BITS-FRAC_BITS-1:0]         q;
      logic [SUM_BITS-FRAC_BITS-COORD_BITS:0] hi;
      q  = s[SUM_BITS-1:FRAC_BITS];
      hi = q[SUM_BITS-FRAC_BITS-1:COORD_BITS-1];
      if ((&hi) || !(|hi)) begin
         return q[COORD_BITS-1:0];
      end
      return s[SUM_BITS-1] ? COORD_MIN : COORD_MAX;
   endfunction

   logic                   s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   vtx_type                s1_vtx_ff;
   logic                   s2_last_ff, s3_last_ff, s4_last_ff;
   logic [2:0][3:0][PROD_BITS-1:0] s2_prod_ff, s2_prod_in;
   logic [2:0][1:0][SUM_BITS-1:0]  s3_pair_ff, s3_pair_in;
   logic [2:0][SUM_BITS-1:0]       s4_sum_ff, s4_sum_in;
   logic [2:0][COORD_BITS-1:0]     coord;
   logic [2:0]                     inflight;
   logic [Q_CNT_BITS:0]            load;
   logic                           accept;

   assign inflight = 3'(s1_valid_ff) + 3'(s2_valid_ff) + 3'(s3_valid_ff) + 3'(s4_valid_ff);
   assign load       = {1'b0, q_stat.count} + (Q_CNT_BITS+1)'(inflight);
   assign req_tready = (load < (Q_CNT_BITS+1)'(Q_DEPTH));
   assign accept     = req_tvalid & req_tready;

   assign coord[0] = s1_vtx_ff.x;
   assign coord[1] = s1_vtx_ff.y;
   assign coord[2] = s1_vtx_ff.z;

   always_comb begin
      logic signed [PROD_BITS-1:0] ca;
      logic signed [PROD_BITS-1:0] cb;
      logic signed [PROD_BITS-1:0] ct;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            ca = PROD_BITS'($signed(coef[r][c]));
            cb = PROD_BITS'($signed(coord[c]));
            s2_prod_in[r][c] = ca * cb;
         end
         ct = PROD_BITS'($signed(coef[r][3]));
         s2_prod_in[r][3] = ct <<< FRAC_BITS;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         s3_pair_in[r][0] = SUM_BITS'($signed(s2_prod_ff[r][0]))
                          + SUM_BITS'($signed(s2_prod_ff[r][1]));
         s3_pair_in[r][1] = SUM_BITS'($signed(s2_prod_ff[r][2]))
                          + SUM_BITS'($signed(s2_prod_ff[r][3]));
         s4_sum_in[r]     = s3_pair_ff[r][0] + s3_pair_ff[r][1];
      end
   end

   assign push.valid       = s4_valid_ff;
   assign push.data.last   = s4_last_ff;
   assign push.data.x      = sat_floor(s4_sum_ff[0]);
   assign push.data.y      = sat_floor(s4_sum_ff[1]);
   assign push.data.z      = sat_floor(s4_sum_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
      s1_vtx_ff.x    <= req_tdata[COORD_BITS-1:0];
      s1_vtx_ff.y    <= req_tdata[2*COORD_BITS-1:COORD_BITS];
      s1_vtx_ff.z    <= req_tdata[3*COORD_BITS-1:2*COORD_BITS];
      s1_vtx_ff.last <= req_tlast;
      s2_last_ff     <= s1_vtx_ff.last;
      s2_prod_ff     <= s2_prod_in;
      s3_last_ff     <= s2_last_ff;
      s3_pair_ff     <= s3_pair_in;
      s4_last_ff     <= s3_last_ff;
      s4_sum_ff      <= s4_sum_in;
   end

endmodule

// ===== rtl/core/tvab_back.sv =====
// Running per-axis min/max accumulator and box output register.
module tvab_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tvab_pkg::vtx_type                    head,
   input  tvab_pkg::q_stat_type                 q_stat,
   output logic                                 pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [tvab_pkg::OUT_TDATA_BITS-1:0]  rsp_tdata
);
   import tvab_pkg::*;

   box_type run_ff, run_in, upd;
   box_type box_ff, box_in;
   logic    valid_ff, valid_in;

   assign pop        = !q_stat.empty && (!head.last || !valid_ff || rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = OUT_TDATA_BITS'(box_ff);

   always_comb begin
      upd.min_x = ($signed(head.x) < $signed(run_ff.min_x)) ? head.x : run_ff.min_x;
      upd.min_y = ($signed(head.y) < $signed(run_ff.min_y)) ? head.y : run_ff.min_y;
      upd.min_z = ($signed(head.z) < $signed(run_ff.min_z)) ? head.z : run_ff.min_z;
      upd.max_x = ($signed(head.x) > $signed(run_ff.max_x)) ? head.x : run_ff.max_x;
      upd.max_y = ($signed(head.y) > $signed(run_ff.max_y)) ? head.y : run_ff.max_y;
      upd.max_z = ($signed(head.z) > $signed(run_ff.max_z)) ? head.z : run_ff.max_z;

      run_in   = run_ff;
      box_in   = box_ff;
      valid_in = valid_ff && !rsp_tready;
      if (pop) begin
         if (head.last) begin
            box_in   = upd;
            valid_in = 1'b1;
            run_in   = '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX};
         end else begin
            run_in   = upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         run_ff   <= '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX};
      end else begin
         valid_ff <= valid_in;
         run_ff   <= run_in;
      end
      box_ff <= box_in;
   end

endmodule

// ===== rtl/core/transformed_vertex_aabb_top.sv =====
// Top level of the transformed-vertex bounding box block.
// Each accepted word is one vertex (signed Q16.16 x, y, z); it is multiplied by the top three
// rows of the configured affine matrix (w = 1), floored to Q16.16 and saturated, and folded
// into running per-axis minima and maxima. The word with tlast set closes the mesh: the box
// including that vertex comes out as one word and the running box returns to empty. One vertex
// is taken every cycle while input ready is high; a vertex passes the input register, the
// multiplier stage and two adder stages into the queue, is folded into the box when popped,
// and loads the box register if it closes the mesh. An eight-entry queue decouples the transform
// pipe from the accumulator; input ready drops only when the queue and the pipe together hold
// eight vertices. Write the matrix registers only while no mesh is in flight.
module transformed_vertex_aabb_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [tvab_pkg::IN_TDATA_BITS-1:0]   req_tdata,  // pos_x, pos_y, pos_z
   input  logic                                 req_tlast,  // last_vertex
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
   output logic [tvab_pkg::OUT_TDATA_BITS-1:0]  rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tvab_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [tvab_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [tvab_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import tvab_pkg::*;

   coef_mat_type coef;
   q_push_type   push;
   q_stat_type   q_stat;
   vtx_type      head;
   logic         pop;

   tvab_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   tvab_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .coef       (coef),
      .q_stat     (q_stat),
      .push       (push)
   );

   tvab_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .stat  (q_stat)
   );

   tvab_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/core/tvab_checker.sv =====
// Port-level checker of the transformed-vertex bounding box block and its bind.
`include "assert_macros.svh"

module tvab_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [tvab_pkg::OUT_TDATA_BITS-1:0]  rsp_tdata
);

   `TVAB_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "box word dropped")

   `TVAB_ASSERT(a_rsp_stable, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "box word changed")

   `TVAB_ASSERT(a_box_ordered, rsp_tvalid |-> ($signed(rsp_tdata[31:0]) <= $signed(rsp_tdata[127:96])) && ($signed(rsp_tdata[63:32]) <= $signed(rsp_tdata[159:128])) && ($signed(rsp_tdata[95:64]) <= $signed(rsp_tdata[191:160])), "box min above max")

   `TVAB_ASSERT_ALWAYS(a_reset_state, reset |=> !rsp_tvalid && req_tready, "bad state after reset")

endmodule

bind transformed_vertex_aabb_top tvab_checker u_tvab_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the transformed-vertex bounding box block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tvab_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int PHASE_ITEMS    = 150;
   localparam int RANDOM_PHASES  = 10;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      ROW0_COLS01, ROW0_COLS23, ROW1_COLS01, ROW1_COLS23, ROW2_COLS01, ROW2_COLS23
   } csr_index_e;

   typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_e;

   typedef logic [CSR_COUNT-1:0][CSR_DATA_BITS-1:0] matrix_rows_t;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [IN_TDATA_BITS-1:0]  req_tdata   = '0;
   logic                      req_tlast   = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic [OUT_TDATA_BITS-1:0] rsp_tdata;
   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_prdata;
   logic                      csr_pready;

   logic [CSR_DATA_BITS-1:0] matrix_reg [CSR_COUNT] = '{
      64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000,
      64'h0, 64'h0, 64'h0000_0000_0001_0000
   };
   logic [COORD_BITS-1:0] box_min [3];
   logic [COORD_BITS-1:0] box_max [3];

   vtx_type vertex_queue [$];
   box_type expected_boxes [$];

   int   queued_count   = 0;
   int   accepted_count = 0;
   int   error_count    = 0;
   int   idle_cycles    = 0;
   int   burst_left     = 0;
   int   gap_left       = 0;
   int   mode_left      = 0;
   logic req_fired      = 1'b0;
   logic rsp_fired      = 1'b0;

   ready_mode_e ready_mode = READY_ALWAYS;
   vtx_type     drive_word;
   vtx_type     seen;
   logic [COORD_BITS-1:0]      moved;
   logic [5:0][COORD_BITS-1:0] want;
   logic [5:0][COORD_BITS-1:0] got;

   string box_field [6] = '{"box_min_x", "box_min_y", "box_min_z",
                            "box_max_x", "box_max_y", "box_max_z"};

   transformed_vertex_aabb_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   function automatic logic [COORD_BITS-1:0] transform_axis(
         input logic [CSR_DATA_BITS-1:0] cols01,
         input logic [CSR_DATA_BITS-1:0] cols23,
         input logic [COORD_BITS-1:0]    x,
         input logic [COORD_BITS-1:0]    y,
         input logic [COORD_BITS-1:0]    z);
      logic signed [127:0] coef [4];
      logic signed [127:0] term [4];
      logic signed [127:0] sum;
      coef[0] = $signed(cols01[COEF_BITS-1:0]);
      coef[1] = $signed(cols01[2*COEF_BITS-1:COEF_BITS]);
      coef[2] = $signed(cols23[COEF_BITS-1:0]);
      coef[3] = $signed(cols23[2*COEF_BITS-1:COEF_BITS]);
      term[0] = $signed(x);
      term[1] = $signed(y);
      term[2] = $signed(z);
      term[3] = 128'sd1 <<< FRAC_BITS;
      sum = '0;
      for (int k = 0; k < 4; k++)
         sum += coef[k] * term[k];
      // floor to the coordinate grid, then clamp
      sum = sum >>> FRAC_BITS;
      if (sum > $signed({1'b0, COORD_MAX}))
         return COORD_MAX;
      if (sum < $signed(COORD_MIN))
         return COORD_MIN;
      return sum[COORD_BITS-1:0];
   endfunction

   function automatic logic [COORD_BITS-1:0] rand_coord();
      case ($urandom_range(0, 9))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2, 3:    return $urandom;
         default: return COORD_BITS'($urandom_range(0, 1 << 23)) - COORD_BITS'(1 << 22);
      endcase
   endfunction

   function automatic matrix_rows_t diag_matrix(input logic [COEF_BITS-1:0] scale,
                                                input logic [COEF_BITS-1:0] shift);
      matrix_rows_t rows;
      rows[ROW0_COLS01] = {COEF_BITS'(0), scale};
      rows[ROW0_COLS23] = {shift, COEF_BITS'(0)};
      rows[ROW1_COLS01] = {scale, COEF_BITS'(0)};
      rows[ROW1_COLS23] = {shift, COEF_BITS'(0)};
      rows[ROW2_COLS01] = '0;
      rows[ROW2_COLS23] = {shift, scale};
      return rows;
   endfunction

   task automatic apb_transfer(input logic write, input csr_index_e idx,
                               input logic [CSR_DATA_BITS-1:0] wdata,
                               output logic [CSR_DATA_BITS-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      if (write)
         matrix_reg[idx] = wdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_verify(input csr_index_e idx);
      logic [CSR_DATA_BITS-1:0] readback;
      apb_transfer(1'b0, idx, '0, readback);
      if (readback !== matrix_reg[idx]) begin
         $display("%0t: register %s expected %h, got %h", $time, idx.name(),
                  matrix_reg[idx], readback);
         error_count++;
      end
   endtask

   task automatic csr_write(input csr_index_e idx, input logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] ignored;
      apb_transfer(1'b1, idx, value, ignored);
      csr_verify(idx);
   endtask

   task automatic load_matrix(input matrix_rows_t rows);
      for (int i = 0; i < CSR_COUNT; i++)
         csr_write(csr_index_e'(i), rows[i]);
      @(posedge clock);
   endtask

   task automatic send_vertex(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                              input logic [COORD_BITS-1:0] z, input logic last);
      vertex_queue.push_back('{last: last, z: z, y: y, x: x});
      queued_count++;
   endtask

   task automatic wait_idle();
      while (accepted_count != queued_count || expected_boxes.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      @(posedge clock);
   endtask

   // sender: bursts of words separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (vertex_queue.size() > 0) begin
            drive_word = vertex_queue.pop_front();
            req_tdata  <= {drive_word.z, drive_word.y, drive_word.x};
            req_tlast  <= drive_word.last;
            req_tvalid <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 48);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern switches between modes
   always @(negedge clock) begin
      if (mode_left == 0) begin
         ready_mode = ready_mode_e'($urandom_range(0, 3));
         mode_left  = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN:   rsp_tready <= ($urandom_range(0, 1) == 1);
         READY_SPARSE: rsp_tready <= ($urandom_range(0, 7) == 0);
         default:      rsp_tready <= ((mode_left % 16) < 4);
      endcase
   end

   always @(posedge clock) begin
      if (reset) begin
         req_fired   = 1'b0;
         idle_cycles = 0;
         for (int a = 0; a < 3; a++) begin
            box_min[a] = COORD_MAX;
            box_max[a] = COORD_MIN;
         end
      end else begin
         req_fired = req_tvalid && req_tready;
         rsp_fired = rsp_tvalid && rsp_tready;
         if (req_fired) begin
            accepted_count++;
            seen = {req_tlast, req_tdata};
            for (int a = 0; a < 3; a++) begin
               moved = transform_axis(matrix_reg[2*a], matrix_reg[2*a+1], seen.x, seen.y, seen.z);
               if ($signed(moved) < $signed(box_min[a]))
                  box_min[a] = moved;
               if ($signed(moved) > $signed(box_max[a]))
                  box_max[a] = moved;
            end
            if (seen.last) begin
               expected_boxes.push_back({box_max[2], box_max[1], box_max[0],
                                         box_min[2], box_min[1], box_min[0]});
               for (int a = 0; a < 3; a++) begin
                  box_min[a] = COORD_MAX;
                  box_max[a] = COORD_MIN;
               end
            end
         end
         if (rsp_fired) begin
            got = rsp_tdata;
            if (expected_boxes.size() == 0) begin
               $display("%0t: unexpected box, expected none, got %h", $time, got);
               error_count++;
            end else begin
               want = expected_boxes.pop_front();
               for (int f = 0; f < 6; f++)
                  if (got[f] !== want[f]) begin
                     $display("%0t: %s expected %h, got %h", $time, box_field[f],
                              want[f], got[f]);
                     error_count++;
                  end
            end
         end
         idle_cycles = (req_fired || rsp_fired) ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   initial begin
      matrix_rows_t rows;
      logic [COEF_BITS-1:0] coef;
      int sent;
      int mesh_len;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < CSR_COUNT; i++)
         csr_verify(csr_index_e'(i));
      @(posedge clock);

      // identity: single-vertex mesh, per-axis extremes, repeated vertex
      send_vertex(COORD_MAX, COORD_MIN, '0, 1'b1);
      send_vertex(COORD_MIN, COORD_MAX, '1, 1'b0);
      send_vertex(32'd1, '0, COORD_MAX, 1'b0);
      send_vertex('1, 32'd1, COORD_MIN, 1'b1);
      send_vertex(32'h1234_5678, 32'hedcb_a988, 32'h0001_8000, 1'b0);
      send_vertex(32'h1234_5678, 32'hedcb_a988, 32'h0001_8000, 1'b1);
      wait_idle();

      // saturation at both ends
      load_matrix({12{32'h7fff_ffff}});
      send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
      send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
      send_vertex('0, '0, '0, 1'b1);
      wait_idle();
      load_matrix({12{32'h8000_0000}});
      send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
      send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
      send_vertex('0, '0, '0, 1'b1);
      wait_idle();

      // half scale: floor toward minus infinity
      load_matrix(diag_matrix(32'h0000_8000, '0));
      send_vertex('1, '1, '1, 1'b1);
      send_vertex(32'd1, 32'd1, 32'd1, 1'b1);
      send_vertex(32'd3, 32'hffff_fffd, COORD_MAX, 1'b1);
      wait_idle();

      // negation overflows past the top
      load_matrix(diag_matrix(32'hffff_0000, 32'h0001_8000));
      send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
      send_vertex(COORD_MAX, '0, '1, 1'b1);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         for (int r = 0; r < CSR_COUNT; r++)
            for (int h = 0; h < 2; h++) begin
               case (phase % 3)
                  0: case ($urandom_range(0, 5))
                        0:       coef = '0;
                        1:       coef = 32'h0001_0000;
                        2:       coef = 32'hffff_0000;
                        default: coef = COEF_BITS'($urandom_range(0, 1 << 19))
                                        - COEF_BITS'(1 << 18);
                     endcase
                  1: coef = $urandom;
                  default: case ($urandom_range(0, 4))
                        0:       coef = 32'h7fff_ffff;
                        1:       coef = 32'h8000_0000;
                        2:       coef = '0;
                        3:       coef = '1;
                        default: coef = COEF_BITS'($urandom_range(0, 1 << 19))
                                        - COEF_BITS'(1 << 18);
                     endcase
               endcase
               rows[r][h*COEF_BITS +: COEF_BITS] = coef;
            end
         load_matrix(rows);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            mesh_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12);
            for (int v = 0; v < mesh_len; v++)
               send_vertex(rand_coord(), rand_coord(), rand_coord(), v == mesh_len - 1);
            sent += mesh_len;
         end
      end

      wait_idle();
      if (error_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
